### rtl/assert_macros.svh
// Assertion macros for the RTL of the rectangle fill block.
// Depends on nothing; included by mono_rect_fill_rop.sv, the one file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLKD(label, clk, rst_n, !(cond), msg)

`endif

### rtl/mrf_pkg.sv
// Package of the monochrome rectangle fill block: types, codes and field widths.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package mrf_pkg;

    localparam int OP_W    = 2;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int MODE_W  = 2;
    localparam int COL_W   = 6;
    localparam int BYTE_W  = 8;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;

    localparam logic [BYTE_W-1:0] FULL_MASK = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_DRAIN,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    // Strobes from the sequencer to the pixel memory.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### rtl/mrf_if.sv
// Handshake channels of the rectangle fill block: command in, response out.
// Depends on mrf_pkg for the field widths.
`timescale 1ns / 1ps

interface mrf_in_if;
    logic                          valid;
    logic                          ready;
    logic [mrf_pkg::OP_W-1:0]      op;
    logic [mrf_pkg::X_W-1:0]       x_pos;
    logic [mrf_pkg::Y_W-1:0]       y_pos;
    logic [mrf_pkg::X_W-1:0]       width_px;
    logic [mrf_pkg::Y_W-1:0]       height_px;
    logic [mrf_pkg::MODE_W-1:0]    color_mode;
    logic [mrf_pkg::COL_W-1:0]     byte_column;
    logic [mrf_pkg::BYTE_W-1:0]    byte_data;

    modport source (
        output valid, op, x_pos, y_pos, width_px, height_px, color_mode,
               byte_column, byte_data,
        input  ready
    );
    modport sink (
        input  valid, op, x_pos, y_pos, width_px, height_px, color_mode,
               byte_column, byte_data,
        output ready
    );
endinterface

interface mrf_out_if;
    logic                          valid;
    logic                          ready;
    logic [mrf_pkg::BYTE_W-1:0]    read_data;
    logic                          done_res;

    modport source (output valid, read_data, done_res, input ready);
    modport sink   (input valid, read_data, done_res, output ready);
endinterface

### rtl/mrf_mem.sv
// Pixel store of the rectangle fill block: one write port, one registered read port.
// Depends on mrf_pkg for the strobe struct and byte width.
`timescale 1ns / 1ps

module mrf_mem #(
    parameter int DEPTH = 3200,
    parameter int AW    = 12
) (
    input  logic                          clk,
    input  mrf_pkg::mem_ctl_t             ctl,
    input  logic [AW-1:0]                 waddr,
    input  logic [mrf_pkg::BYTE_W-1:0]    wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [mrf_pkg::BYTE_W-1:0]    rdata
);

    logic [mrf_pkg::BYTE_W-1:0] store_mem [DEPTH];
    logic [mrf_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mrf_rop.sv
// Raster operation unit: builds the edge mask of one byte and applies clear, set or invert.
// Depends on mrf_pkg for the mode codes and the full mask.
`timescale 1ns / 1ps

module mrf_rop (
    input  logic [mrf_pkg::BYTE_W-1:0]    old_byte,
    input  logic                          first_col,
    input  logic                          last_col,
    input  logic [2:0]                    x_lo,
    input  logic [2:0]                    x_last_lo,
    input  logic [mrf_pkg::MODE_W-1:0]    mode,
    output logic [mrf_pkg::BYTE_W-1:0]    new_byte
);

    logic [mrf_pkg::BYTE_W-1:0] mask_lo;
    logic [mrf_pkg::BYTE_W-1:0] mask_hi;
    logic [mrf_pkg::BYTE_W-1:0] mask;

    // Only the first and last bytes of a row span are partial.
    assign mask_lo = mrf_pkg::FULL_MASK << (first_col ? x_lo : 3'd0);
    assign mask_hi = mrf_pkg::FULL_MASK >> (last_col ? (3'd7 - x_last_lo) : 3'd0);
    assign mask    = mask_lo & mask_hi;

    always_comb
    begin
        case (mode)
            mrf_pkg::MODE_CLEAR: new_byte = old_byte & ~mask;
            mrf_pkg::MODE_SET:   new_byte = old_byte | mask;
            default:             new_byte = old_byte ^ mask;
        endcase
    end

endmodule

### rtl/mono_rect_fill_rop.sv
// Top level of the monochrome rectangle fill block: sequencer, address walker and result register.
// Depends on mrf_pkg, mrf_if, mrf_mem, mrf_rop and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block holds LINE_COUNT rows of ceil(LINE_PIXELS/8) bytes, leftmost pixel in bit 0,
// and takes one command at a time: a byte write, a byte read or a rectangle fill with
// clear, set or invert. After reset a clearing pass zeroes the store, one byte a cycle,
// so the command channel stays not ready until the last byte of the store is cleared.
// An empty or off-buffer fill touches nothing; any other fill sends every byte it covers
// through a read-modify-write over the single memory port pair, one byte per cycle.
// A new command is accepted while the previous response still waits to be taken.
module mono_rect_fill_rop #(
    parameter int LINE_PIXELS = 400,
    parameter int LINE_COUNT  = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    mrf_in_if.sink        cmd,
    mrf_out_if.source     rsp
);

    localparam int ROW_BYTES   = (LINE_PIXELS + 7) / 8;
    localparam int STORE_BYTES = LINE_COUNT * ROW_BYTES;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam logic [9:0]    LP_L     = 10'(LINE_PIXELS);
    localparam logic [8:0]    LC_L     = 9'(LINE_COUNT);
    localparam logic [6:0]    RB_L     = 7'(ROW_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);
    localparam logic [AW-1:0] RB_A     = AW'(ROW_BYTES);

    mrf_pkg::state_t state_reg;
    mrf_pkg::state_t state_next;

    // Captured command fields.
    logic [mrf_pkg::OP_W-1:0]   op_reg;
    logic [mrf_pkg::X_W-1:0]    x_reg;
    logic [mrf_pkg::Y_W-1:0]    y_reg;
    logic [mrf_pkg::X_W-1:0]    w_reg;
    logic [mrf_pkg::Y_W-1:0]    h_reg;
    logic [mrf_pkg::MODE_W-1:0] mode_reg;
    logic [mrf_pkg::COL_W-1:0]  bcol_reg;
    logic [mrf_pkg::BYTE_W-1:0] bdata_reg;

    // Fill walker.
    logic [mrf_pkg::X_W-1:0]    x_last_reg;
    logic [8:0]                 y_end_reg;
    logic [mrf_pkg::COL_W-1:0]  first_col_reg;
    logic [mrf_pkg::COL_W-1:0]  last_col_reg;
    logic [mrf_pkg::COL_W-1:0]  col_reg;
    logic [8:0]                 row_reg;
    logic [AW-1:0]              row_base_reg;
    logic [AW-1:0]              clr_cnt_reg;

    // Write-back stage of the read-modify-write pipeline.
    logic                       wb_vld_reg;
    logic [AW-1:0]              wb_addr_reg;
    logic                       wb_first_reg;
    logic                       wb_last_reg;

    logic [mrf_pkg::BYTE_W-1:0] res_data_reg;
    logic                       res_done_reg;
    logic                       out_valid_reg;
    logic [mrf_pkg::BYTE_W-1:0] out_data_reg;
    logic                       out_done_reg;

    logic [9:0]                 x_end_sum;
    logic [9:0]                 x_end_clip;
    logic [mrf_pkg::X_W-1:0]    x_last;
    logic [8:0]                 y_end_sum;
    logic [8:0]                 y_end_clip;
    logic                       fill_ok;
    logic                       byte_ok;
    logic [AW-1:0]              byte_addr;
    logic [AW-1:0]              row_start;
    logic [AW-1:0]              fill_addr;
    logic                       col_last;
    logic                       row_last;
    logic                       out_free;
    logic                       cmd_acc;

    mrf_pkg::mem_ctl_t          mem_ctl;
    logic [AW-1:0]              mem_waddr;
    logic [mrf_pkg::BYTE_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [mrf_pkg::BYTE_W-1:0] mem_rdata;
    logic [mrf_pkg::BYTE_W-1:0] rop_byte;

    mrf_mem #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mrf_rop u_rop (
        .old_byte  (mem_rdata),
        .first_col (wb_first_reg),
        .last_col  (wb_last_reg),
        .x_lo      (x_reg[2:0]),
        .x_last_lo (x_last_reg[2:0]),
        .mode      (mode_reg),
        .new_byte  (rop_byte)
    );

    // Geometry of the command, used in the setup cycle.
    assign x_end_sum  = {1'b0, x_reg} + {1'b0, w_reg};
    assign x_end_clip = (x_end_sum > LP_L) ? LP_L : x_end_sum;
    assign x_last     = mrf_pkg::X_W'(x_end_clip - 10'd1);
    assign y_end_sum  = {1'b0, y_reg} + {1'b0, h_reg};
    assign y_end_clip = (y_end_sum > LC_L) ? LC_L : y_end_sum;
    assign fill_ok    = (w_reg != '0) && (h_reg != '0) && ({1'b0, x_reg} < LP_L)
                        && ({1'b0, y_reg} < LC_L);
    assign byte_ok    = ({1'b0, y_reg} < LC_L) && ({1'b0, bcol_reg} < RB_L);
    assign row_start  = AW'(32'(y_reg) * 32'(ROW_BYTES));
    assign byte_addr  = AW'(32'(y_reg) * 32'(ROW_BYTES) + 32'(bcol_reg));
    assign fill_addr  = row_base_reg + AW'(col_reg);
    assign col_last   = (col_reg == last_col_reg);
    assign row_last   = ((row_reg + 9'd1) == y_end_reg);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign cmd_acc    = cmd.valid && cmd.ready;

    assign cmd.ready     = (state_reg == mrf_pkg::ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.done_res  = out_done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrf_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = mrf_pkg::ST_IDLE;
                end
            end
            mrf_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = mrf_pkg::ST_SETUP;
                end
            end
            mrf_pkg::ST_SETUP:
            begin
                if (op_reg == mrf_pkg::OP_READ && byte_ok)
                begin
                    state_next = mrf_pkg::ST_RD_WAIT;
                end
                else if (op_reg == mrf_pkg::OP_FILL && fill_ok)
                begin
                    state_next = mrf_pkg::ST_FILL;
                end
                else
                begin
                    state_next = mrf_pkg::ST_DONE;
                end
            end
            mrf_pkg::ST_FILL:
            begin
                if (col_last && row_last)
                begin
                    state_next = mrf_pkg::ST_DRAIN;
                end
            end
            mrf_pkg::ST_DRAIN:   state_next = mrf_pkg::ST_DONE;
            mrf_pkg::ST_RD_WAIT: state_next = mrf_pkg::ST_DONE;
            mrf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mrf_pkg::ST_IDLE;
                end
            end
            default:             state_next = mrf_pkg::ST_IDLE;
        endcase
    end

    // Memory port selection. The clearing pass, a byte write and the fill write-back
    // never fall in the same cycle, so the write port needs no arbitration.
    always_comb
    begin
        mem_ctl   = '0;
        mem_waddr = wb_addr_reg;
        mem_wdata = rop_byte;
        mem_raddr = fill_addr;
        if (wb_vld_reg)
        begin
            mem_ctl.we = 1'b1;
        end
        unique case (state_reg)
            mrf_pkg::ST_CLEAR:
            begin
                mem_ctl.we = 1'b1;
                mem_waddr  = clr_cnt_reg;
                mem_wdata  = '0;
            end
            mrf_pkg::ST_SETUP:
            begin
                if (op_reg == mrf_pkg::OP_WRITE && byte_ok)
                begin
                    mem_ctl.we = 1'b1;
                    mem_waddr  = byte_addr;
                    mem_wdata  = bdata_reg;
                end
                if (op_reg == mrf_pkg::OP_READ && byte_ok)
                begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = byte_addr;
                end
            end
            mrf_pkg::ST_FILL:
            begin
                mem_ctl.re = 1'b1;
            end
            default:
            begin
                mem_ctl.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrf_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            wb_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wb_vld_reg <= (state_reg == mrf_pkg::ST_FILL);
            if (state_reg == mrf_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == mrf_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            op_reg    <= cmd.op;
            x_reg     <= cmd.x_pos;
            y_reg     <= cmd.y_pos;
            w_reg     <= cmd.width_px;
            h_reg     <= cmd.height_px;
            mode_reg  <= cmd.color_mode;
            bcol_reg  <= cmd.byte_column;
            bdata_reg <= cmd.byte_data;
        end

        if (state_reg == mrf_pkg::ST_SETUP)
        begin
            x_last_reg    <= x_last;
            y_end_reg     <= y_end_clip;
            first_col_reg <= x_reg[mrf_pkg::X_W-1:3];
            last_col_reg  <= x_last[mrf_pkg::X_W-1:3];
            col_reg       <= x_reg[mrf_pkg::X_W-1:3];
            row_reg       <= {1'b0, y_reg};
            row_base_reg  <= row_start;
            res_data_reg  <= '0;
            res_done_reg  <= (op_reg == mrf_pkg::OP_WRITE) || (op_reg == mrf_pkg::OP_READ)
                             || (op_reg == mrf_pkg::OP_FILL);
        end

        if (state_reg == mrf_pkg::ST_FILL)
        begin
            if (col_last)
            begin
                col_reg      <= first_col_reg;
                row_reg      <= row_reg + 9'd1;
                row_base_reg <= row_base_reg + RB_A;
            end
            else
            begin
                col_reg <= col_reg + 6'd1;
            end
        end

        wb_addr_reg  <= fill_addr;
        wb_first_reg <= (col_reg == first_col_reg);
        wb_last_reg  <= col_last;

        if (state_reg == mrf_pkg::ST_RD_WAIT)
        begin
            res_data_reg <= mem_rdata;
        end

        if (state_reg == mrf_pkg::ST_DONE && out_free)
        begin
            out_data_reg <= res_data_reg;
            out_done_reg <= res_done_reg;
        end
    end

    `ASSERT_NEVER(a_no_write_when_ready, clk, rst_n, cmd.ready && mem_ctl.we, "memory written while idle")
    `ASSERT_CLKD(a_wb_follows_fill, clk, rst_n, wb_vld_reg |-> $past(state_reg == mrf_pkg::ST_FILL), "write-back without a fill read")
    `ASSERT_CLKD(a_read_issued, clk, rst_n, (state_reg == mrf_pkg::ST_RD_WAIT) |-> $past(mem_ctl.re), "read wait without a read")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the monochrome rectangle fill block: directed and random byte writes, reads and fills.
// Depends on mrf_pkg, the mrf_in_if and mrf_out_if interfaces and mono_rect_fill_rop.

module tb_top;

    localparam int LINE_PIXELS = 400;
    localparam int LINE_COUNT  = 64;
    localparam int ROW_BYTES   = (LINE_PIXELS + 7) / 8;
    localparam int STORE_BYTES = LINE_COUNT * ROW_BYTES;
    localparam int MAX_WAIT    = 13;
    localparam int RANDOM_CMDS = 700;
    localparam int MAX_REPORTS = 100;

    localparam logic [mrf_pkg::OP_W-1:0]   OP_NONE     = 2'd3;
    localparam logic [mrf_pkg::MODE_W-1:0] MODE_INVERT = 2'd2;
    localparam logic [mrf_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;

    typedef struct {
        logic [mrf_pkg::OP_W-1:0]   op;
        logic [mrf_pkg::X_W-1:0]    x_pos;
        logic [mrf_pkg::Y_W-1:0]    y_pos;
        logic [mrf_pkg::X_W-1:0]    width_px;
        logic [mrf_pkg::Y_W-1:0]    height_px;
        logic [mrf_pkg::MODE_W-1:0] color_mode;
        logic [mrf_pkg::COL_W-1:0]  byte_column;
        logic [mrf_pkg::BYTE_W-1:0] byte_data;
        int                         lead_gap;
        bit                         drain_first;
    } rect_cmd_t;

    typedef struct {
        logic [mrf_pkg::BYTE_W-1:0] read_data;
        logic                       done_res;
    } rop_reply_t;

    logic clk;
    logic rst_n;

    mrf_in_if  cmd_ch ();
    mrf_out_if rsp_ch ();

    mono_rect_fill_rop uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    logic [mrf_pkg::BYTE_W-1:0] shadow_px [STORE_BYTES];
    rect_cmd_t                  pending_cmds [$];
    rop_reply_t                 expected_replies [$];
    rect_cmd_t                  cmd_on_bus;

    int cmds_sent;
    int replies_seen;
    int cmd_idle;
    int rsp_hold;
    int next_stall;
    int mismatch_count = 0;
    bit gap_armed;
    bit stim_calm = 1'b0;
    bit hold_next = 1'b0;

    // Applies one command to the shadow store and records the reply it must give.
    task automatic run_pixel_op(input rect_cmd_t c);
        int                         x_end;
        int                         y_end;
        int                         row;
        int                         col;
        int                         lo_bit;
        int                         hi_bit;
        int                         addr;
        logic [mrf_pkg::BYTE_W-1:0] mask;
        rop_reply_t                 r;
        r.read_data = '0;
        r.done_res  = 1'b1;
        addr = int'(c.y_pos) * ROW_BYTES + int'(c.byte_column);
        case (c.op)
            mrf_pkg::OP_WRITE:
            begin
                if (c.y_pos < LINE_COUNT && c.byte_column < ROW_BYTES)
                    shadow_px[addr] = c.byte_data;
            end
            mrf_pkg::OP_READ:
            begin
                if (c.y_pos < LINE_COUNT && c.byte_column < ROW_BYTES)
                    r.read_data = shadow_px[addr];
            end
            mrf_pkg::OP_FILL:
            begin
                if (c.width_px != 0 && c.height_px != 0 &&
                    c.x_pos < LINE_PIXELS && c.y_pos < LINE_COUNT)
                begin
                    x_end = int'(c.x_pos) + int'(c.width_px);
                    if (x_end > LINE_PIXELS)
                        x_end = LINE_PIXELS;
                    y_end = int'(c.y_pos) + int'(c.height_px);
                    if (y_end > LINE_COUNT)
                        y_end = LINE_COUNT;
                    for (row = int'(c.y_pos); row < y_end; row++)
                    begin
                        for (col = int'(c.x_pos) / 8; col <= (x_end - 1) / 8; col++)
                        begin
                            lo_bit = (int'(c.x_pos) > col * 8) ? int'(c.x_pos) - col * 8 : 0;
                            hi_bit = (x_end < col * 8 + 8) ? x_end - col * 8 : 8;
                            mask = (mrf_pkg::FULL_MASK << lo_bit)
                                   & (mrf_pkg::FULL_MASK >> (8 - hi_bit));
                            addr = row * ROW_BYTES + col;
                            if (c.color_mode == mrf_pkg::MODE_CLEAR)
                                shadow_px[addr] = shadow_px[addr] & ~mask;
                            else if (c.color_mode == mrf_pkg::MODE_SET)
                                shadow_px[addr] = shadow_px[addr] | mask;
                            else
                                shadow_px[addr] = shadow_px[addr] ^ mask;
                        end
                    end
                end
            end
            default:
                r.done_res = 1'b0;
        endcase
        expected_replies.push_back(r);
    endtask

    task automatic check_reply(input logic [mrf_pkg::BYTE_W-1:0] got_data,
                               input logic got_done);
        rop_reply_t want;
        if (expected_replies.size() == 0)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: reply with none expected: read_data %h done_res %b",
                         $time, got_data, got_done);
            mismatch_count++;
        end
        else
        begin
            want = expected_replies.pop_front();
            if (got_data !== want.read_data)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: read_data expected %h, got %h",
                             $time, want.read_data, got_data);
                mismatch_count++;
            end
            if (got_done !== want.done_res)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: done_res expected %b, got %b",
                             $time, want.done_res, got_done);
                mismatch_count++;
            end
        end
    endtask

    task automatic queue_cmd(input logic [mrf_pkg::OP_W-1:0] op, input int x, input int y,
                             input int w, input int h,
                             input logic [mrf_pkg::MODE_W-1:0] mode,
                             input int col, input int data);
        rect_cmd_t c;
        c.op          = op;
        c.x_pos       = x[mrf_pkg::X_W-1:0];
        c.y_pos       = y[mrf_pkg::Y_W-1:0];
        c.width_px    = w[mrf_pkg::X_W-1:0];
        c.height_px   = h[mrf_pkg::Y_W-1:0];
        c.color_mode  = mode;
        c.byte_column = col[mrf_pkg::COL_W-1:0];
        c.byte_data   = data[mrf_pkg::BYTE_W-1:0];
        c.lead_gap    = stim_calm ? 0 : $urandom_range(0, MAX_WAIT);
        c.drain_first = hold_next;
        hold_next     = 1'b0;
        pending_cmds.push_back(c);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        int k;
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.op           = '0;
        cmd_ch.x_pos        = '0;
        cmd_ch.y_pos        = '0;
        cmd_ch.width_px     = '0;
        cmd_ch.height_px    = '0;
        cmd_ch.color_mode   = '0;
        cmd_ch.byte_column  = '0;
        cmd_ch.byte_data    = '0;
        rsp_ch.ready        = 1'b0;
        for (k = 0; k < STORE_BYTES; k++)
            shadow_px[k] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Command driver: each beat waits out its own lead gap, and some wait for an empty pipe.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_idle     <= 0;
            gap_armed    <= 1'b0;
            cmds_sent    <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                run_pixel_op(cmd_on_bus);
                cmds_sent <= cmds_sent + 1;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_idle != 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    cmd_idle     <= cmd_idle - 1;
                end
                else if (pending_cmds.size() != 0 &&
                         (!pending_cmds[0].drain_first ||
                          (!cmd_ch.valid && cmds_sent == replies_seen)))
                begin
                    if (!gap_armed && pending_cmds[0].lead_gap != 0)
                    begin
                        cmd_ch.valid <= 1'b0;
                        cmd_idle     <= pending_cmds[0].lead_gap - 1;
                        gap_armed    <= 1'b1;
                    end
                    else
                    begin
                        cmd_on_bus = pending_cmds.pop_front();
                        cmd_ch.op          <= cmd_on_bus.op;
                        cmd_ch.x_pos       <= cmd_on_bus.x_pos;
                        cmd_ch.y_pos       <= cmd_on_bus.y_pos;
                        cmd_ch.width_px    <= cmd_on_bus.width_px;
                        cmd_ch.height_px   <= cmd_on_bus.height_px;
                        cmd_ch.color_mode  <= cmd_on_bus.color_mode;
                        cmd_ch.byte_column <= cmd_on_bus.byte_column;
                        cmd_ch.byte_data   <= cmd_on_bus.byte_data;
                        cmd_ch.valid       <= 1'b1;
                        gap_armed          <= 1'b0;
                    end
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Reply monitor: stalls at random after a beat, except in alternate stretches of 32 beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold     <= 0;
            replies_seen <= 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            check_reply(rsp_ch.read_data, rsp_ch.done_res);
            replies_seen <= replies_seen + 1;
            next_stall = ((replies_seen / 32) % 2 == 1) ? $urandom_range(0, MAX_WAIT) : 0;
            rsp_hold     <= next_stall;
            rsp_ch.ready <= (next_stall == 0);
        end
        else if (rsp_hold != 0)
        begin
            rsp_hold     <= rsp_hold - 1;
            rsp_ch.ready <= (rsp_hold == 1);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    initial
    begin
        int                         i;
        int                         pick;
        int                         x;
        int                         y;
        int                         w;
        int                         h;
        int                         roll;
        int                         col;
        int                         data;
        bit                         big;
        logic [mrf_pkg::MODE_W-1:0] mode;
        logic [mrf_pkg::OP_W-1:0]   op;

        // A fresh store reads as zero, and bytes written in range read back.
        queue_cmd(mrf_pkg::OP_READ, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, 0, 0);
        queue_cmd(mrf_pkg::OP_WRITE, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, 0, 'hA5);
        queue_cmd(mrf_pkg::OP_READ, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, 0, 0);
        queue_cmd(mrf_pkg::OP_WRITE, 0, LINE_COUNT - 1, 0, 0, mrf_pkg::MODE_CLEAR,
                  ROW_BYTES - 1, 'hFF);
        queue_cmd(mrf_pkg::OP_READ, 0, LINE_COUNT - 1, 0, 0, mrf_pkg::MODE_CLEAR,
                  ROW_BYTES - 1, 0);
        // Byte accesses past the last row or column are ignored and read as zero.
        queue_cmd(mrf_pkg::OP_WRITE, 0, LINE_COUNT, 0, 0, mrf_pkg::MODE_CLEAR, 0, 'h3C);
        queue_cmd(mrf_pkg::OP_WRITE, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, ROW_BYTES, 'h81);
        queue_cmd(mrf_pkg::OP_READ, 0, 255, 0, 0, mrf_pkg::MODE_CLEAR, 63, 0);
        // Empty and off-buffer rectangles leave the store alone.
        queue_cmd(mrf_pkg::OP_FILL, 0, 0, 0, 5, mrf_pkg::MODE_SET, 0, 0);
        queue_cmd(mrf_pkg::OP_FILL, 0, 0, 7, 0, mrf_pkg::MODE_SET, 0, 0);
        queue_cmd(mrf_pkg::OP_FILL, LINE_PIXELS, 0, 10, 1, mrf_pkg::MODE_SET, 0, 0);
        queue_cmd(mrf_pkg::OP_FILL, 511, 255, 511, 255, mrf_pkg::MODE_SET, 0, 0);
        // Narrow spans in one byte, one byte-aligned byte and a clear over three bytes of two rows.
        queue_cmd(mrf_pkg::OP_FILL, 3, 0, 2, 1, mrf_pkg::MODE_SET, 0, 0);
        queue_cmd(mrf_pkg::OP_FILL, 8, 0, 8, 1, MODE_INVERT, 0, 0);
        queue_cmd(mrf_pkg::OP_READ, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, 1, 0);
        queue_cmd(mrf_pkg::OP_FILL, 1, 0, 20, 2, mrf_pkg::MODE_CLEAR, 0, 0);
        queue_cmd(mrf_pkg::OP_READ, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, 0, 0);
        // Whole-buffer fills clipped at right and bottom, a spare-mode fill inside, unused ops.
        queue_cmd(mrf_pkg::OP_FILL, 0, 0, 511, 255, mrf_pkg::MODE_SET, 0, 0);
        queue_cmd(mrf_pkg::OP_READ, 0, LINE_COUNT - 1, 0, 0, mrf_pkg::MODE_CLEAR,
                  ROW_BYTES - 1, 0);
        queue_cmd(mrf_pkg::OP_FILL, 5, 10, 300, 40, MODE_SPARE, 0, 0);
        queue_cmd(mrf_pkg::OP_READ, 0, 20, 0, 0, mrf_pkg::MODE_CLEAR, 20, 0);
        queue_cmd(mrf_pkg::OP_FILL, 0, 0, 511, 255, mrf_pkg::MODE_CLEAR, 0, 0);
        queue_cmd(mrf_pkg::OP_READ, 0, 20, 0, 0, mrf_pkg::MODE_CLEAR, 20, 0);
        queue_cmd(OP_NONE, 511, 255, 511, 255, MODE_SPARE, 63, 255);
        queue_cmd(OP_NONE, 0, 0, 0, 0, mrf_pkg::MODE_CLEAR, 0, 0);

        for (i = 0; i < RANDOM_CMDS; i++)
        begin
            stim_calm = ((i / 60) % 3 == 1);
            if (i % 150 == 0)
                hold_next = 1'b1;
            pick = $urandom_range(0, 99);
            x    = $urandom_range(0, 511);
            y    = $urandom_range(0, 255);
            w    = $urandom_range(0, 511);
            h    = $urandom_range(0, 255);
            roll = $urandom_range(0, 3);
            mode = roll[mrf_pkg::MODE_W-1:0];
            col  = $urandom_range(0, 63);
            data = $urandom_range(0, 255);
            if (pick < 40)
            begin
                op  = mrf_pkg::OP_FILL;
                // Most rectangles are small and near the buffer; a few take any width and height.
                big = ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 9) != 0)
                begin
                    x = $urandom_range(0, LINE_PIXELS + 15);
                    y = $urandom_range(0, LINE_COUNT + 2);
                end
                if (!big)
                begin
                    w = $urandom_range(0, 40);
                    h = $urandom_range(0, 8);
                end
                roll = $urandom_range(int'(mrf_pkg::MODE_CLEAR), int'(MODE_INVERT));
                mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : roll[mrf_pkg::MODE_W-1:0];
            end
            else
            begin
                if (pick < 75)
                    op = mrf_pkg::OP_READ;
                else if (pick < 95)
                    op = mrf_pkg::OP_WRITE;
                else
                    op = OP_NONE;
                if ($urandom_range(0, 19) > 2)
                begin
                    y   = $urandom_range(0, LINE_COUNT - 1);
                    col = $urandom_range(0, ROW_BYTES - 1);
                end
            end
            queue_cmd(op, x, y, w, h, mode, col, data);
        end

        wait (rst_n === 1'b1);
        // Sampled on the falling edge so that the driver and monitor have settled.
        while (pending_cmds.size() != 0 || cmd_ch.valid || cmds_sent != replies_seen)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/mrf_pkg.sv
rtl/mrf_if.sv
rtl/mrf_mem.sv
rtl/mrf_rop.sv
rtl/mono_rect_fill_rop.sv
bench/tb_top.sv
